>>> hdl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler-to-quaternion unit
// Arctangent table, CORDIC formats and rounding helpers.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int IN_W      = 26;
    localparam int MAX_STEPS = 30;
    localparam int CW        = 33;   // CORDIC x/y width, Q30 plus sign and growth
    localparam int ZW        = 34;   // angle accumulator width, Q24 degrees
    localparam int PW        = 64;   // product width
    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [IN_W:0] HALF_180 = 27'sd23592960;
    localparam logic signed [IN_W:0] HALF_90  = 27'sd11796480;
    localparam logic signed [IN_W:0] HALF_360 = 27'sd47185920;

    typedef logic signed [CW-1:0] q30_t;
    typedef logic signed [ZW-1:0] ang_t;

    // sine and cosine of one half angle
    typedef struct packed {
        q30_t c;
        q30_t s;
    } sincos_t;

    function automatic ang_t atan_q24(input int i);
        ang_t t;
        unique case (i)
            0:  t = 34'sd754974720;
            1:  t = 34'sd445687602;
            2:  t = 34'sd235489088;
            3:  t = 34'sd119537938;
            4:  t = 34'sd60000934;
            5:  t = 34'sd30029717;
            6:  t = 34'sd15018523;
            7:  t = 34'sd7509720;
            8:  t = 34'sd3754917;
            9:  t = 34'sd1877466;
            10: t = 34'sd938734;
            11: t = 34'sd469367;
            12: t = 34'sd234684;
            13: t = 34'sd117342;
            14: t = 34'sd58671;
            15: t = 34'sd29335;
            16: t = 34'sd14668;
            17: t = 34'sd7334;
            18: t = 34'sd3667;
            19: t = 34'sd1833;
            20: t = 34'sd917;
            21: t = 34'sd458;
            22: t = 34'sd229;
            23: t = 34'sd115;
            24: t = 34'sd57;
            25: t = 34'sd29;
            26: t = 34'sd14;
            27: t = 34'sd7;
            28: t = 34'sd4;
            29: t = 34'sd2;
            default: t = '0;
        endcase
        return t;
    endfunction

    // product shifted right by 30 with round half up
    function automatic q30_t rnd30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] r;
        r = (p + (64'sd1 <<< 29)) >>> 30;
        return r[CW-1:0];
    endfunction

endpackage

>>> hdl/e2q_cordic_lane.sv
// ----------------------------------------------------------------------------
// e2q_cordic_lane: half-angle sine/cosine lane
// Folds the half angle to +/-90 degrees and runs a pipelined rotation CORDIC,
// one iteration per stage.
// ----------------------------------------------------------------------------
module e2q_cordic_lane
    import e2q_pkg::*;
#(
    parameter int STEPS = 18
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] angle,
    output sincos_t                res
);

    localparam int NS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

    q30_t x_reg [0:NS];
    q30_t y_reg [0:NS];
    ang_t z_reg [0:NS];
    logic neg_reg [0:NS];

    logic signed [IN_W:0] h0;
    logic signed [IN_W:0] h1;
    logic signed [IN_W:0] h2;
    logic                 neg0;

    // fold into -180..180 then -90..90
    always_comb
    begin
        h0 = {angle[IN_W-1], angle};
        if (h0 > HALF_180)
            h1 = h0 - HALF_360;
        else if (h0 < -HALF_180)
            h1 = h0 + HALF_360;
        else
            h1 = h0;
        neg0 = 1'b0;
        if (h1 > HALF_90)
        begin
            h2   = h1 - HALF_180;
            neg0 = 1'b1;
        end
        else if (h1 < -HALF_90)
        begin
            h2   = h1 + HALF_180;
            neg0 = 1'b1;
        end
        else
            h2 = h1;
    end

    // stage 0 load
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= ZW'(h2) <<< 7;
            neg_reg[0] <= neg0;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NS; i++)
    begin : g_it
        q30_t dx;
        q30_t dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - atan_q24(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + atan_q24(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign res.c = neg_reg[NS] ? -x_reg[NS] : x_reg[NS];
    assign res.s = neg_reg[NS] ? -y_reg[NS] : y_reg[NS];

endmodule

>>> hdl/e2q_merge.sv
// ----------------------------------------------------------------------------
// e2q_merge: triple products and component sums
// Pipelined: first products, second products, sums with round and saturate.
// ----------------------------------------------------------------------------
module e2q_merge
    import e2q_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            en,
    input  sincos_t                         yaw,
    input  sincos_t                         pitch,
    input  sincos_t                         roll,
    output logic signed [OUT_FRAC_BITS+1:0] quat_w,
    output logic signed [OUT_FRAC_BITS+1:0] quat_x,
    output logic signed [OUT_FRAC_BITS+1:0] quat_y,
    output logic signed [OUT_FRAC_BITS+1:0] quat_z
);

    localparam int FB = (OUT_FRAC_BITS > 30) ? 30 : OUT_FRAC_BITS;
    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int SH = 30 - FB;

    // products a*b and the third factor, eight terms
    q30_t ab_reg [0:7];
    q30_t c1_reg [0:7];
    q30_t t_reg  [0:7];
    logic signed [CW:0] sum_reg [0:3];

    q30_t fa [0:7];
    q30_t fb [0:7];
    q30_t fc [0:7];

    always_comb
    begin
        // W terms
        fa[0] = yaw.c; fb[0] = pitch.c; fc[0] = roll.c;
        fa[1] = yaw.s; fb[1] = pitch.s; fc[1] = roll.s;
        // X terms
        fa[2] = yaw.c; fb[2] = pitch.c; fc[2] = roll.s;
        fa[3] = yaw.s; fb[3] = pitch.s; fc[3] = roll.c;
        // Y terms
        fa[4] = yaw.c; fb[4] = pitch.s; fc[4] = roll.c;
        fa[5] = yaw.s; fb[5] = pitch.c; fc[5] = roll.s;
        // Z terms
        fa[6] = yaw.s; fb[6] = pitch.c; fc[6] = roll.c;
        fa[7] = yaw.c; fb[7] = pitch.s; fc[7] = roll.s;
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_term
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ab_reg[k] <= rnd30(PW'(fa[k]) * PW'(fb[k]));
                c1_reg[k] <= fc[k];
                t_reg[k]  <= rnd30(PW'(ab_reg[k]) * PW'(c1_reg[k]));
            end
        end
    end

    // component sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0] <= (CW+1)'(t_reg[0]) + (CW+1)'(t_reg[1]);
            sum_reg[1] <= (CW+1)'(t_reg[2]) - (CW+1)'(t_reg[3]);
            sum_reg[2] <= (CW+1)'(t_reg[4]) + (CW+1)'(t_reg[5]);
            sum_reg[3] <= (CW+1)'(t_reg[6]) - (CW+1)'(t_reg[7]);
        end
    end

    // round to output format and clamp to +/-1
    logic signed [OW-1:0] q [0:3];
    for (genvar k = 0; k < 4; k++)
    begin : g_out
        logic signed [CW+1:0] r;
        logic signed [CW+1:0] one;
        always_comb
        begin
            if (SH == 0)
                r = (CW+2)'(sum_reg[k]);
            else
                r = ((CW+2)'(sum_reg[k]) + ((CW+2)'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
            one = (CW+2)'(1) <<< FB;
            if (r > one)
                q[k] = OW'(one);
            else if (r < -one)
                q[k] = OW'(-one);
            else
                q[k] = OW'(r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_w <= q[0];
            quat_x <= q[1];
            quat_y <= q[2];
            quat_z <= q[3];
        end
    end

endmodule

>>> hdl/euler_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit: yaw/pitch/roll (Z-Y-X) to unit quaternion
// Three CORDIC lanes feed a product/sum merge pipeline.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, set by the fully pipelined CORDIC lanes,
// while the output register is not held by out_stall.
// The pipeline advances whenever the output register is empty or being taken.
// Reset clears the valid pipeline only; data registers are not reset.
module euler_to_quaternion_unit
    import e2q_pkg::*;
#(
    parameter int CORDIC_STEPS  = 18,
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [IN_W-1:0]          yaw_deg,
    input  logic signed [IN_W-1:0]          pitch_deg,
    input  logic signed [IN_W-1:0]          roll_deg,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [OUT_FRAC_BITS+1:0] quat_w,
    output logic signed [OUT_FRAC_BITS+1:0] quat_x,
    output logic signed [OUT_FRAC_BITS+1:0] quat_y,
    output logic signed [OUT_FRAC_BITS+1:0] quat_z
);

    localparam int NS  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int LAT = NS + 5;

    logic           en;
    logic [LAT-1:0] vld_reg;
    sincos_t        sc_y;
    sincos_t        sc_p;
    sincos_t        sc_r;

    // whole pipeline moves together unless the output item is held
    assign en        = !(vld_reg[LAT-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    e2q_cordic_lane #(.STEPS(NS)) u_yaw
    (
        .clk(clk), .en(en), .angle(yaw_deg), .res(sc_y)
    );
    e2q_cordic_lane #(.STEPS(NS)) u_pitch
    (
        .clk(clk), .en(en), .angle(pitch_deg), .res(sc_p)
    );
    e2q_cordic_lane #(.STEPS(NS)) u_roll
    (
        .clk(clk), .en(en), .angle(roll_deg), .res(sc_r)
    );

    e2q_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge
    (
        .clk(clk), .en(en), .yaw(sc_y), .pitch(sc_p), .roll(sc_r),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    // held output item stays valid with quat_w and quat_z unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(quat_w) && $stable(quat_z))
        else $error("output item changed while stalled");

    // input is stalled only when the output item is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // an accepted item enters the first pipeline stage
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted item missing from pipeline");

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for euler_to_quaternion_unit
// Drives yaw/pitch/roll items through a directed table and then random items.
// Each accepted item is predicted bit-exactly by a CORDIC model written here.
// Results are compared field by field, in order. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS    = 18;
    localparam int OFB      = 16;
    localparam int LATENCY  = STEPS + 5;
    localparam int N_RAND   = 1500;
    localparam int LIMIT    = 400000;
    localparam longint HDEG = 131072;
    localparam longint ONE  = 64'sd1 <<< OFB;

    typedef logic signed [OFB+1:0] qout_t;
    typedef struct packed {
        qout_t w;
        qout_t x;
        qout_t y;
        qout_t z;
    } quat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic signed [25:0] yaw_deg = '0;
    logic signed [25:0] pitch_deg = '0;
    logic signed [25:0] roll_deg = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    qout_t             quat_w, quat_x, quat_y, quat_z;

    quat_t  quat_expected[$];
    int     errors = 0;
    int     cycles = 0;
    int     sent = 0;
    bit     quiet = 0;     // no idling on either side
    bit     hold_req = 0;  // receiver long hold-off request

    euler_to_quaternion_unit #(
        .CORDIC_STEPS(STEPS),
        .OUT_FRAC_BITS(OFB)
    ) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .yaw_deg(yaw_deg), .pitch_deg(pitch_deg), .roll_deg(roll_deg),
        .out_valid(out_valid), .out_stall(out_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint round_shift(longint v, int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint t [30] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                           30029717, 15018523, 7509720, 3754917, 1877466,
                           938734, 469367, 234684, 117342, 58671,
                           29335, 14668, 7334, 3667, 1833,
                           917, 458, 229, 115, 57, 29, 14, 7, 4, 2};
        return t[i];
    endfunction

    // cosine and sine (Q30) of half the raw angle
    task automatic half_angle_sincos(input logic signed [25:0] raw,
                                     output longint c, output longint s);
        longint h, x, y, z, dx, dy;
        bit     flip;
        h = raw;
        flip = 0;
        x = 652032874;
        y = 0;
        if (h > 180 * HDEG)
            h -= 360 * HDEG;
        else if (h < -180 * HDEG)
            h += 360 * HDEG;
        if (h > 90 * HDEG)
        begin
            h -= 180 * HDEG;
            flip = 1;
        end
        else if (h < -90 * HDEG)
        begin
            h += 180 * HDEG;
            flip = 1;
        end
        z = h * 128;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_entry(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_entry(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint prod3(longint a, longint b, longint c);
        return round_shift(round_shift(a * b, 30) * c, 30);
    endfunction

    function automatic qout_t to_q16(longint q30);
        longint v;
        v = round_shift(q30, 30 - OFB);
        if (v > ONE)
            v = ONE;
        if (v < -ONE)
            v = -ONE;
        return qout_t'(v);
    endfunction

    task automatic predict_quat(input logic signed [25:0] yw, pt, rl,
                                output quat_t q);
        longint cy, sy, cp, sp, cr, sr;
        half_angle_sincos(yw, cy, sy);
        half_angle_sincos(pt, cp, sp);
        half_angle_sincos(rl, cr, sr);
        q.w = to_q16(prod3(cy, cp, cr) + prod3(sy, sp, sr));
        q.x = to_q16(prod3(cy, cp, sr) - prod3(sy, sp, cr));
        q.y = to_q16(prod3(cy, sp, cr) + prod3(sy, cp, sr));
        q.z = to_q16(prod3(sy, cp, cr) - prod3(cy, sp, sr));
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict accepted items, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        quat_t q, e;
        cycles++;
        if (in_valid && !in_stall && rst_n)
        begin
            predict_quat(yaw_deg, pitch_deg, roll_deg, q);
            quat_expected.push_back(q);
        end
        if (out_valid && !out_stall && rst_n)
        begin
            if (quat_expected.size() == 0)
            begin
                $display("%0t: result with no item pending w=%0d x=%0d y=%0d z=%0d",
                         $time, quat_w, quat_x, quat_y, quat_z);
                errors++;
            end
            else
            begin
                e = quat_expected.pop_front();
                if (quat_w !== e.w)
                begin
                    $display("%0t: quat_w expected %0d actual %0d", $time, e.w, quat_w);
                    errors++;
                end
                if (quat_x !== e.x)
                begin
                    $display("%0t: quat_x expected %0d actual %0d", $time, e.x, quat_x);
                    errors++;
                end
                if (quat_y !== e.y)
                begin
                    $display("%0t: quat_y expected %0d actual %0d", $time, e.y, quat_y);
                    errors++;
                end
                if (quat_z !== e.z)
                begin
                    $display("%0t: quat_z expected %0d actual %0d", $time, e.z, quat_z);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold == 0)
            begin
                hold = 400;
                hold_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (!quiet && $urandom_range(99) < 31);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_item(input logic signed [25:0] yw, pt, rl);
        while (!quiet && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            yaw_deg <= 26'($urandom);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        yaw_deg   <= yw;
        pitch_deg <= pt;
        roll_deg  <= rl;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (quat_expected.size() != 0)
            @(negedge clk);
    endtask

    // random angle: full field, nominal range, or near a fold boundary
    function automatic logic signed [25:0] pick_angle();
        int sel;
        int bnd [6] = '{11796480, 23592960, 5898240, 0, 17694720, 33554431};
        sel = $urandom_range(9);
        if (sel < 3)
            return 26'($urandom);
        else if (sel < 8)
            return 26'(int'($urandom_range(47185920)) - 23592960);
        else
        begin
            pick_angle = 26'(bnd[$urandom_range(5)] + int'($urandom_range(4)) - 2);
            if ($urandom_range(1))
                pick_angle = -pick_angle;
        end
    endfunction

    // directed items: zero, extremes, fold boundaries, gimbal lock
    logic signed [25:0] dir_tab [21][3] = '{
        '{0, 0, 0},
        '{23592960, 0, 0},
        '{-23592960, 0, 0},
        '{0, 23592960, 0},
        '{0, 0, -23592960},
        '{33554431, 33554431, 33554431},
        '{-33554432, -33554432, -33554432},
        '{23592961, -23592961, 23592961},
        '{11796480, 11796480, 11796480},
        '{11796481, -11796481, 11796481},
        '{-11796480, -11796481, 11796479},
        '{5898240, 0, 0},
        '{0, 5898240, 0},
        '{0, 0, 5898240},
        '{0, -5898240, 0},
        '{5898240, 5898240, 5898240},
        '{-5898240, 5898240, -5898240},
        '{1, -1, 1},
        '{2949120, 1966080, 983040},
        '{-33554432, 0, 33554431},
        '{17694720, -17694720, 8847360}
    };

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i][0], dir_tab[i][1], dir_tab[i][2]);
        // sender pause until everything is back
        wait_drained();

        for (int n = 0; n < N_RAND; n++)
        begin
            quiet = (n >= 900 && n < 1100);
            if (n == 300)
                hold_req = 1;
            if (n == 700)
                wait_drained();
            send_item(pick_angle(), pick_angle(), pick_angle());
        end
        quiet = 0;
        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);

        if (errors == 0 && quat_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/e2q_pkg.sv
hdl/e2q_cordic_lane.sv
hdl/e2q_merge.sv
hdl/euler_to_quaternion_unit.sv
sim/tb.sv
